### src/thsc_pkg.sv
// Shared types, constants and the helper function for the thermostat controller.
// No dependencies; every other file in src refers to this package by scoped name.

package thsc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int IDLE_BITS   = 16;
    localparam int BTN_IDX_W   = 2;
    localparam int TEMP_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};

    localparam logic signed [TEMP_W-1:0] SP_MIN = -12'sd400;
    localparam logic signed [TEMP_W-1:0] SP_MAX = 12'sd1250;

    localparam logic [9:0]  DEBOUNCE_RST      = 10'd30;
    localparam logic [13:0] BLINK_PERIOD_RST  = 14'd350;
    localparam logic [15:0] BLINK_DUR_RST     = 16'd5000;
    localparam logic [15:0] BACKLIGHT_DUR_RST = 16'd10000;
    localparam logic [6:0]  HYST_RST          = 7'd5;
    localparam logic [6:0]  STEP_RST          = 7'd5;
    localparam logic signed [TEMP_W-1:0] INIT_SP_RST = 12'sd200;

    localparam logic [BTN_IDX_W-1:0] BTN_UP   = 2'd0;
    localparam logic [BTN_IDX_W-1:0] BTN_DOWN = 2'd1;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_EDGE = 2'd1,
        CMD_MEAS = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        DISP_KEEP  = 2'd0,
        DISP_SHOW  = 2'd1,
        DISP_BLANK = 2'd2
    } t_disp;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_BLINK_PERIOD  = 3'd1,
        CFG_BLINK_DUR     = 3'd2,
        CFG_BACKLIGHT_DUR = 3'd3,
        CFG_HYST          = 3'd4,
        CFG_STEP          = 3'd5,
        CFG_INIT_SP       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]                debounce;
        logic [13:0]               blink_period;
        logic [15:0]               blink_dur;
        logic [15:0]               backlight_dur;
        logic [6:0]                hyst;
        logic [6:0]                step;
        logic signed [TEMP_W-1:0]  init_sp;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [BTN_IDX_W-1:0]      button_index;
        logic                      pin_level;
        logic signed [TEMP_W-1:0]  measured_temp;
        logic                      measure_valid;
        logic signed [TEMP_W-1:0]  schedule_setpoint;
    } t_item;

    typedef struct packed {
        logic                      relay_on;
        logic                      backlight_on;
        logic [1:0]                display_action;
        logic signed [TEMP_W-1:0]  display_value;
        logic                      heater_changed;
        logic                      setpoint_committed;
    } t_result;

    // Button bank status toward the controller.
    typedef struct packed {
        logic press;          // debounced press of any in-range button
        logic step_up;        // press of the up button
        logic step_down;      // press of the down button
        logic idle_blink;     // every button idle longer than blink duration
        logic idle_backlight; // every button idle longer than backlight duration
    } t_btn_evt;

    // Hysteresis check: return the relay level after the check.
    function automatic logic heater_next(input logic on,
                                         input logic signed [TEMP_W-1:0] sp,
                                         input logic signed [TEMP_W-1:0] temp,
                                         input logic [6:0] hyst,
                                         input logic forced);
        logic signed [TEMP_W+1:0] s;
        logic signed [TEMP_W+1:0] t;
        logic signed [TEMP_W+1:0] h;
        logic                     res;
        s = {{2{sp[TEMP_W-1]}}, sp};
        t = {{2{temp[TEMP_W-1]}}, temp};
        h = {{(TEMP_W-5){1'b0}}, hyst};
        if (on) begin
            res = !((s <= t - h) || (forced && (s <= t)));
        end else begin
            res = (s >= t + h) || (forced && (s > t));
        end
        return res;
    endfunction

endpackage

### src/thermostat_setpoint_and_heater_control.sv
// Top level of the thermostat controller: register file, input and result stages.
// Depends on thsc_pkg, thsc_buttons and thsc_ctrl.

// Bang-bang thermostat working in tenths of a degree. Each transfer on the
// input channel is one item: a 1 ms tick, a button pin edge or a temperature
// measurement, and each item yields exactly one result transfer. An item is
// captured into the input register, processed by the button bank and the
// controller once the output register is free or draining, and its result
// lands in the output register. The block sustains one item per clock while
// the consumer does not stall: the input register is refilled in the same
// cycle its item moves on, and o_stall rises only when the output register
// holds a result that the consumer is stalling. The result stays valid in
// the output register until it transfers. The seven control registers are
// written over the cfg port at any time (o_cfg_ready is tied high); indexes
// beyond the list are dropped. Write them only while no item is in flight.
// Writing initial_setpoint also reloads the active and edit setpoints.

module thermostat_setpoint_and_heater_control (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [1:0]                            i_cmd,
    input  logic [thsc_pkg::BTN_IDX_W-1:0]        i_button_index,
    input  logic                                  i_pin_level,
    input  logic signed [thsc_pkg::TEMP_W-1:0]    i_measured_temp,
    input  logic                                  i_measure_valid,
    input  logic signed [thsc_pkg::TEMP_W-1:0]    i_schedule_setpoint,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_relay_on,
    output logic                                  o_backlight_on,
    output logic [1:0]                            o_display_action,
    output logic signed [thsc_pkg::TEMP_W-1:0]    o_display_value,
    output logic                                  o_heater_changed,
    output logic                                  o_setpoint_committed,
    // register write port
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [thsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [thsc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    thsc_pkg::t_cfg     r_cfg;
    thsc_pkg::t_item    r_in;
    logic               r_in_valid;
    thsc_pkg::t_result  r_out;
    logic               r_out_valid;
    thsc_pkg::t_result  res;
    thsc_pkg::t_btn_evt evt;

    logic in_xfer;
    logic proc_en;
    logic cfg_wr;
    logic load_sp;

    // Process the held item whenever the output register is free or draining.
    assign proc_en = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !proc_en;
    assign in_xfer = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign load_sp     = cfg_wr && (i_cfg_index == thsc_pkg::CFG_INIT_SP);

    // Register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce      <= thsc_pkg::DEBOUNCE_RST;
            r_cfg.blink_period  <= thsc_pkg::BLINK_PERIOD_RST;
            r_cfg.blink_dur     <= thsc_pkg::BLINK_DUR_RST;
            r_cfg.backlight_dur <= thsc_pkg::BACKLIGHT_DUR_RST;
            r_cfg.hyst          <= thsc_pkg::HYST_RST;
            r_cfg.step          <= thsc_pkg::STEP_RST;
            r_cfg.init_sp       <= thsc_pkg::INIT_SP_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                thsc_pkg::CFG_DEBOUNCE:      r_cfg.debounce      <= i_cfg_data[9:0];
                thsc_pkg::CFG_BLINK_PERIOD:  r_cfg.blink_period  <= i_cfg_data[13:0];
                thsc_pkg::CFG_BLINK_DUR:     r_cfg.blink_dur     <= i_cfg_data[15:0];
                thsc_pkg::CFG_BACKLIGHT_DUR: r_cfg.backlight_dur <= i_cfg_data[15:0];
                thsc_pkg::CFG_HYST:          r_cfg.hyst          <= i_cfg_data[6:0];
                thsc_pkg::CFG_STEP:          r_cfg.step          <= i_cfg_data[6:0];
                thsc_pkg::CFG_INIT_SP: begin
                    r_cfg.init_sp <= $signed(i_cfg_data[thsc_pkg::TEMP_W-1:0]);
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Input register: hold the item until the controller takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc_en) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.cmd               <= i_cmd;
            r_in.button_index      <= i_button_index;
            r_in.pin_level         <= i_pin_level;
            r_in.measured_temp     <= i_measured_temp;
            r_in.measure_valid     <= i_measure_valid;
            r_in.schedule_setpoint <= i_schedule_setpoint;
        end
    end

    thsc_buttons u_buttons (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc_en),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_evt   (evt)
    );

    thsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (proc_en),
        .i_item     (r_in),
        .i_cfg      (r_cfg),
        .i_evt      (evt),
        .i_load_sp  (load_sp),
        .i_load_val ($signed(i_cfg_data[thsc_pkg::TEMP_W-1:0])),
        .o_res      (res)
    );

    // Result register: advance on each processed item, drop once transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_en) begin
            r_out <= res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_relay_on           = r_out.relay_on;
    assign o_backlight_on       = r_out.backlight_on;
    assign o_display_action     = r_out.display_action;
    assign o_display_value      = r_out.display_value;
    assign o_heater_changed     = r_out.heater_changed;
    assign o_setpoint_committed = r_out.setpoint_committed;

endmodule

### src/thsc_buttons.sv
// Per-button debounce: held flags and saturating idle counters, plus idle checks.
// Depends on thsc_pkg.

module thsc_buttons (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  thsc_pkg::t_item   i_item,
    input  thsc_pkg::t_cfg    i_cfg,
    output thsc_pkg::t_btn_evt o_evt
);

    logic [thsc_pkg::NUM_BUTTONS-1:0] r_held;
    logic [thsc_pkg::NUM_BUTTONS-1:0] n_held;
    logic [thsc_pkg::IDLE_BITS-1:0]   r_idle [thsc_pkg::NUM_BUTTONS];
    logic [thsc_pkg::IDLE_BITS-1:0]   n_idle [thsc_pkg::NUM_BUTTONS];
    logic [thsc_pkg::IDLE_BITS-1:0]   idle_inc [thsc_pkg::NUM_BUTTONS];
    logic [thsc_pkg::NUM_BUTTONS-1:0] press;
    logic [thsc_pkg::NUM_BUTTONS-1:0] over_blink;
    logic [thsc_pkg::NUM_BUTTONS-1:0] over_bl;

    always_comb begin
        for (int i = 0; i < thsc_pkg::NUM_BUTTONS; i++) begin
            idle_inc[i]   = (r_idle[i] == thsc_pkg::IDLE_MAX) ? r_idle[i] : r_idle[i] + 1'b1;
            // Idle checks are only used on ticks, so judge the aged count.
            over_blink[i] = idle_inc[i] > thsc_pkg::IDLE_BITS'(i_cfg.blink_dur);
            over_bl[i]    = idle_inc[i] > thsc_pkg::IDLE_BITS'(i_cfg.backlight_dur);
            n_held[i]     = r_held[i];
            n_idle[i]     = r_idle[i];
            press[i]      = 1'b0;
            if (i_en && i_item.cmd == thsc_pkg::CMD_TICK) begin
                n_idle[i] = idle_inc[i];
            end else if (i_en && i_item.cmd == thsc_pkg::CMD_EDGE &&
                         i_item.button_index == thsc_pkg::BTN_IDX_W'(i) &&
                         r_idle[i] > thsc_pkg::IDLE_BITS'(i_cfg.debounce)) begin
                if (!i_item.pin_level && !r_held[i]) begin
                    press[i]  = 1'b1;
                    n_held[i] = 1'b1;
                    n_idle[i] = '0;
                end else if (i_item.pin_level && r_held[i]) begin
                    n_held[i] = 1'b0;
                    n_idle[i] = '0;
                end
            end
        end
    end

    always_comb begin
        o_evt.press          = |press;
        o_evt.step_up        = press[thsc_pkg::BTN_UP];
        o_evt.step_down      = press[thsc_pkg::BTN_DOWN];
        o_evt.idle_blink     = &over_blink;
        o_evt.idle_backlight = &over_bl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            for (int i = 0; i < thsc_pkg::NUM_BUTTONS; i++) begin
                r_idle[i] <= thsc_pkg::IDLE_MAX;
            end
        end else begin
            r_held <= n_held;
            for (int i = 0; i < thsc_pkg::NUM_BUTTONS; i++) begin
                r_idle[i] <= n_idle[i];
            end
        end
    end

endmodule

### src/thsc_ctrl.sv
// Setpoint edit, blink and backlight timing, temperature and heater relay state.
// Depends on thsc_pkg; takes button events from thsc_buttons.

module thsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  thsc_pkg::t_item    i_item,
    input  thsc_pkg::t_cfg     i_cfg,
    input  thsc_pkg::t_btn_evt i_evt,
    input  logic               i_load_sp,
    input  logic signed [thsc_pkg::TEMP_W-1:0] i_load_val,
    output thsc_pkg::t_result  o_res
);

    logic r_heat, n_heat;
    logic r_edit_on, n_edit_on;
    logic r_phase, n_phase;
    logic r_backlight, n_backlight;
    logic [13:0] r_timer, n_timer;
    logic signed [thsc_pkg::TEMP_W-1:0] r_active, n_active;
    logic signed [thsc_pkg::TEMP_W-1:0] r_edit_sp, n_edit_sp;
    logic signed [thsc_pkg::TEMP_W-1:0] r_temp, n_temp;

    logic [14:0] timer_inc;
    logic [13:0] period;
    logic signed [thsc_pkg::TEMP_W+1:0] stepped;
    logic signed [thsc_pkg::TEMP_W-1:0] sp_meas;
    logic show;
    logic committed;
    logic [1:0] action;
    logic signed [thsc_pkg::TEMP_W-1:0] value;

    always_comb begin
        n_heat      = r_heat;
        n_edit_on   = r_edit_on;
        n_phase     = r_phase;
        n_backlight = r_backlight;
        n_timer     = r_timer;
        n_active    = r_active;
        n_edit_sp   = r_edit_sp;
        n_temp      = r_temp;
        show        = 1'b0;
        committed   = 1'b0;
        action      = thsc_pkg::DISP_KEEP;
        value       = '0;
        timer_inc   = {1'b0, r_timer} + 15'd1;
        period      = (i_cfg.blink_period == '0) ? 14'd1 : i_cfg.blink_period;
        stepped     = i_evt.step_up
                    ? {{2{r_edit_sp[thsc_pkg::TEMP_W-1]}}, r_edit_sp} + 14'sd0 +
                      $signed({7'b0, i_cfg.step})
                    : {{2{r_edit_sp[thsc_pkg::TEMP_W-1]}}, r_edit_sp} -
                      $signed({7'b0, i_cfg.step});
        sp_meas     = r_edit_on ? r_active : i_item.schedule_setpoint;

        if (i_en) begin
            case (i_item.cmd)
                thsc_pkg::CMD_TICK: begin
                    if (timer_inc >= {1'b0, period}) begin
                        n_timer = '0;
                        if (r_backlight) begin
                            if (i_evt.idle_backlight) begin
                                n_backlight = 1'b0;
                            end
                            if (r_edit_on) begin
                                if (i_evt.idle_blink) begin
                                    n_active  = r_edit_sp;
                                    show      = r_edit_sp != r_temp;
                                    n_heat    = thsc_pkg::heater_next(r_heat, r_edit_sp,
                                                    r_temp, i_cfg.hyst, 1'b1);
                                    n_edit_on = 1'b0;
                                    committed = 1'b1;
                                end else begin
                                    show    = !r_phase;
                                    n_phase = !r_phase;
                                end
                                if (show) begin
                                    action = thsc_pkg::DISP_SHOW;
                                    value  = r_edit_sp;
                                end else begin
                                    action = thsc_pkg::DISP_BLANK;
                                end
                            end
                        end
                    end else begin
                        n_timer = timer_inc[13:0];
                    end
                end
                thsc_pkg::CMD_EDGE: begin
                    if (i_evt.press) begin
                        n_backlight = 1'b1;
                        if (i_evt.step_up || i_evt.step_down) begin
                            if (r_edit_on) begin
                                if (stepped < 14'(thsc_pkg::SP_MIN)) begin
                                    n_edit_sp = thsc_pkg::SP_MIN;
                                end else if (stepped > 14'(thsc_pkg::SP_MAX)) begin
                                    n_edit_sp = thsc_pkg::SP_MAX;
                                end else begin
                                    n_edit_sp = stepped[thsc_pkg::TEMP_W-1:0];
                                end
                            end else begin
                                n_edit_sp = r_active;
                                n_edit_on = 1'b1;
                            end
                        end
                    end
                end
                thsc_pkg::CMD_MEAS: begin
                    n_active = sp_meas;
                    if (i_item.measure_valid) begin
                        n_temp = i_item.measured_temp;
                        if (sp_meas != i_item.measured_temp && !r_edit_on) begin
                            action = thsc_pkg::DISP_SHOW;
                            value  = sp_meas;
                        end
                        n_heat = thsc_pkg::heater_next(r_heat, sp_meas,
                                     i_item.measured_temp, i_cfg.hyst, 1'b0);
                    end
                end
                default: begin
                end
            endcase
        end

        // Port setpoint reload wins; user must send it only while idle, unchecked.
        if (i_load_sp) begin
            n_active  = i_load_val;
            n_edit_sp = i_load_val;
        end
    end

    always_comb begin
        o_res.relay_on           = n_heat;
        o_res.backlight_on       = n_backlight;
        o_res.display_action     = action;
        o_res.display_value      = value;
        o_res.heater_changed     = n_heat != r_heat;
        o_res.setpoint_committed = committed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat      <= 1'b0;
            r_edit_on   <= 1'b0;
            r_phase     <= 1'b0;
            r_backlight <= 1'b0;
            r_timer     <= '0;
            r_active    <= thsc_pkg::INIT_SP_RST;
            r_edit_sp   <= thsc_pkg::INIT_SP_RST;
            r_temp      <= '0;
        end else begin
            r_heat      <= n_heat;
            r_edit_on   <= n_edit_on;
            r_phase     <= n_phase;
            r_backlight <= n_backlight;
            r_timer     <= n_timer;
            r_active    <= n_active;
            r_edit_sp   <= n_edit_sp;
            r_temp      <= n_temp;
        end
    end

endmodule

### tb/thsc_result_checker.sv
// Result checker for the thermostat controller: follows the item, result and register
// channels, predicts every result from its own copy of the controller state.
// Depends on thsc_pkg only.

module thsc_result_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_item_valid,
    input  logic                                  i_item_stall,
    input  logic [1:0]                            i_cmd,
    input  logic [thsc_pkg::BTN_IDX_W-1:0]        i_button_index,
    input  logic                                  i_pin_level,
    input  logic signed [thsc_pkg::TEMP_W-1:0]    i_measured_temp,
    input  logic                                  i_measure_valid,
    input  logic signed [thsc_pkg::TEMP_W-1:0]    i_schedule_setpoint,
    input  logic                                  i_res_valid,
    input  logic                                  i_res_stall,
    input  logic                                  i_relay_on,
    input  logic                                  i_backlight_on,
    input  logic [1:0]                            i_display_action,
    input  logic signed [thsc_pkg::TEMP_W-1:0]    i_display_value,
    input  logic                                  i_heater_changed,
    input  logic                                  i_setpoint_committed,
    input  logic                                  i_cfg_valid,
    input  logic                                  i_cfg_ready,
    input  logic [thsc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [thsc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output int                                    o_mismatches,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import thsc_pkg::*;

    t_cfg                       regs;
    logic                       heating;
    logic                       editing;
    logic                       blink_phase;
    logic                       backlight;
    logic signed [TEMP_W-1:0]   active_sp;
    logic signed [TEMP_W-1:0]   edit_sp;
    logic signed [TEMP_W-1:0]   room_temp;
    logic                       btn_held [NUM_BUTTONS];
    logic [IDLE_BITS-1:0]       btn_idle [NUM_BUTTONS];
    logic [13:0]                blink_count;
    t_result                    results_due [$];

    task automatic reset_state();
        int i;
        regs.debounce      = DEBOUNCE_RST;
        regs.blink_period  = BLINK_PERIOD_RST;
        regs.blink_dur     = BLINK_DUR_RST;
        regs.backlight_dur = BACKLIGHT_DUR_RST;
        regs.hyst          = HYST_RST;
        regs.step          = STEP_RST;
        regs.init_sp       = INIT_SP_RST;
        heating     = 1'b0;
        editing     = 1'b0;
        blink_phase = 1'b0;
        backlight   = 1'b0;
        active_sp   = INIT_SP_RST;
        edit_sp     = INIT_SP_RST;
        room_temp   = '0;
        blink_count = '0;
        for (i = 0; i < NUM_BUTTONS; i++) begin
            btn_held[i] = 1'b0;
            btn_idle[i] = IDLE_MAX;
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_DEBOUNCE:      regs.debounce = data[9:0];
            CFG_BLINK_PERIOD:  regs.blink_period = data[13:0];
            CFG_BLINK_DUR:     regs.blink_dur = data;
            CFG_BACKLIGHT_DUR: regs.backlight_dur = data;
            CFG_HYST:          regs.hyst = data[6:0];
            CFG_STEP:          regs.step = data[6:0];
            CFG_INIT_SP: begin
                // the initial setpoint also reloads both working setpoints
                regs.init_sp = data[TEMP_W-1:0];
                active_sp    = data[TEMP_W-1:0];
                edit_sp      = data[TEMP_W-1:0];
            end
            default: ;
        endcase
    endtask

    function automatic logic all_idle_over(input logic [15:0] limit);
        int i;
        for (i = 0; i < NUM_BUTTONS; i++) begin
            if (!(btn_idle[i] > limit)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Hysteresis check on the relay; returns 1 when the relay switched.
    function automatic logic relay_update(input logic forced);
        int   sp;
        int   tmp;
        int   h;
        logic was;
        sp  = active_sp;
        tmp = room_temp;
        h   = regs.hyst;
        was = heating;
        if (heating) begin
            if (sp <= tmp - h || (forced && sp <= tmp)) heating = 1'b0;
        end else begin
            if (sp >= tmp + h || (forced && sp > tmp)) heating = 1'b1;
        end
        return was != heating;
    endfunction

    task automatic predict_result(input t_item it, output t_result r);
        int                   period;
        int                   stepped;
        int                   st;
        int                   i;
        logic                 show;
        logic [BTN_IDX_W-1:0] b;
        r = '0;
        b = it.button_index;
        case (it.cmd)
            CMD_TICK: begin
                for (i = 0; i < NUM_BUTTONS; i++) begin
                    if (btn_idle[i] != IDLE_MAX) btn_idle[i] = btn_idle[i] + 1'b1;
                end
                period = (regs.blink_period == 0) ? 1 : int'(regs.blink_period);
                if (int'(blink_count) + 1 >= period) begin
                    blink_count = '0;
                    // evaluation only while lit, lit state taken before the timeout
                    if (backlight) begin
                        if (all_idle_over(regs.backlight_dur)) backlight = 1'b0;
                        if (editing) begin
                            if (all_idle_over(regs.blink_dur)) begin
                                active_sp            = edit_sp;
                                show                 = active_sp != room_temp;
                                r.heater_changed     = relay_update(1'b1);
                                editing              = 1'b0;
                                r.setpoint_committed = 1'b1;
                            end else begin
                                show        = !blink_phase;
                                blink_phase = !blink_phase;
                            end
                            if (show) begin
                                r.display_action = DISP_SHOW;
                                r.display_value  = edit_sp;
                            end else begin
                                r.display_action = DISP_BLANK;
                            end
                        end
                    end
                end else begin
                    blink_count = blink_count + 1'b1;
                end
            end
            CMD_EDGE: begin
                if (b < NUM_BUTTONS) begin
                    if (btn_idle[b] > regs.debounce) begin
                        if (!it.pin_level && !btn_held[b]) begin
                            backlight = 1'b1;
                            if (b == BTN_UP || b == BTN_DOWN) begin
                                if (editing) begin
                                    stepped = edit_sp;
                                    st      = regs.step;
                                    stepped = (b == BTN_UP) ? stepped + st : stepped - st;
                                    if (stepped < SP_MIN) stepped = SP_MIN;
                                    if (stepped > SP_MAX) stepped = SP_MAX;
                                    edit_sp = stepped[TEMP_W-1:0];
                                end else begin
                                    edit_sp = active_sp;
                                    editing = 1'b1;
                                end
                            end
                            btn_held[b] = 1'b1;
                            btn_idle[b] = '0;
                        end else if (it.pin_level && btn_held[b]) begin
                            btn_held[b] = 1'b0;
                            btn_idle[b] = '0;
                        end
                    end
                end
            end
            CMD_MEAS: begin
                if (!editing) active_sp = it.schedule_setpoint;
                if (it.measure_valid) begin
                    room_temp = it.measured_temp;
                    if (active_sp != room_temp && !editing) begin
                        r.display_action = DISP_SHOW;
                        r.display_value  = active_sp;
                    end
                    r.heater_changed = relay_update(1'b0);
                end
            end
            default: ;
        endcase
        r.relay_on     = heating;
        r.backlight_on = backlight;
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_item   item;
        if (!i_rst_n) begin
            reset_state();
            results_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            // compare before adding this edge's item: a result is never that young
            if (i_res_valid && !i_res_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result expected none, got relay %0d light %0d %0d/%0d",
                             $time, i_relay_on, i_backlight_on, i_display_action,
                             i_display_value);
                    o_mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("relay_on", want.relay_on, i_relay_on);
                    check_field("backlight_on", want.backlight_on, i_backlight_on);
                    check_field("display_action", want.display_action, i_display_action);
                    check_field("display_value", want.display_value, i_display_value);
                    check_field("heater_changed", want.heater_changed, i_heater_changed);
                    check_field("setpoint_committed", want.setpoint_committed,
                                i_setpoint_committed);
                end
            end
            if (i_item_valid && !i_item_stall) begin
                item.cmd               = i_cmd;
                item.button_index      = i_button_index;
                item.pin_level         = i_pin_level;
                item.measured_temp     = i_measured_temp;
                item.measure_valid     = i_measure_valid;
                item.schedule_setpoint = i_schedule_setpoint;
                predict_result(item, want);
                results_due.push_back(want);
            end
        end
        o_pending = results_due.size();
    end

endmodule

### tb/thermostat_setpoint_and_heater_control_test.sv
// Top of the thermostat controller testbench: clock, reset, stimulus and verdict.
// Depends on thsc_pkg, the controller RTL and thsc_result_checker.

module thermostat_setpoint_and_heater_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    import thsc_pkg::*;

    // Codes the package leaves unnamed: the spare command, the mode button,
    // the button index past the bank and a register index past the list.
    localparam logic [1:0]           CMD_UNDEFINED  = 2'd3;
    localparam logic [BTN_IDX_W-1:0] BTN_MODE       = 2'd2;
    localparam logic [BTN_IDX_W-1:0] BTN_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
    localparam int                   WATCHDOG_LIMIT = 2000;
    localparam int                   SETTLE_CYCLES  = 6;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic [1:0]               cmd;
    logic [BTN_IDX_W-1:0]     button_index;
    logic                     pin_level;
    logic signed [TEMP_W-1:0] measured_temp;
    logic                     measure_valid;
    logic signed [TEMP_W-1:0] schedule_setpoint;
    logic                     res_valid;
    logic                     res_stall;
    logic                     relay_on;
    logic                     backlight_on;
    logic [1:0]               display_action;
    logic signed [TEMP_W-1:0] display_value;
    logic                     heater_changed;
    logic                     setpoint_committed;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    int                       mismatches;
    int                       pending;

    // Sender pacing and knowledge of the current register setting.
    int burst_left;
    int sent;
    int cur_hyst;
    int sched_base;
    int tick_run_max;
    int tick_wait_max;
    int idle_cycles;

    thermostat_setpoint_and_heater_control uut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_valid              (item_valid),
        .o_stall              (item_stall),
        .i_cmd                (cmd),
        .i_button_index       (button_index),
        .i_pin_level          (pin_level),
        .i_measured_temp      (measured_temp),
        .i_measure_valid      (measure_valid),
        .i_schedule_setpoint  (schedule_setpoint),
        .o_valid              (res_valid),
        .i_stall              (res_stall),
        .o_relay_on           (relay_on),
        .o_backlight_on       (backlight_on),
        .o_display_action     (display_action),
        .o_display_value      (display_value),
        .o_heater_changed     (heater_changed),
        .o_setpoint_committed (setpoint_committed),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    thsc_result_checker result_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_item_valid         (item_valid),
        .i_item_stall         (item_stall),
        .i_cmd                (cmd),
        .i_button_index       (button_index),
        .i_pin_level          (pin_level),
        .i_measured_temp      (measured_temp),
        .i_measure_valid      (measure_valid),
        .i_schedule_setpoint  (schedule_setpoint),
        .i_res_valid          (res_valid),
        .i_res_stall          (res_stall),
        .i_relay_on           (relay_on),
        .i_backlight_on       (backlight_on),
        .i_display_action     (display_action),
        .i_display_value      (display_value),
        .i_heater_changed     (heater_changed),
        .i_setpoint_committed (setpoint_committed),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data),
        .o_mismatches         (mismatches),
        .o_pending            (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: alternate runs of stall and flow, now and then a long
    // stretch with no stall at all. Change only at the falling edge.
    initial begin
        int run_left;
        logic level;
        res_stall = 1'b0;
        run_left  = 0;
        level     = 1'b0;
        forever begin
            @(negedge clk);
            if (run_left == 0) begin
                case ($urandom_range(0, 5))
                    0: begin
                        level    = 1'b0;
                        run_left = $urandom_range(50, 200);
                    end
                    1, 2: begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 12);
                    end
                    default: begin
                        level    = 1'b0;
                        run_left = $urandom_range(1, 6);
                    end
                endcase
            end
            res_stall = level;
            run_left--;
        end
    end

    // Watchdog: count cycles with no transfer on any channel, bail out at the limit.
    always @(posedge clk) begin
        if ((item_valid && !item_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (rst_n) begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL thermostat_setpoint_and_heater_control");
            $finish;
        end
    end

    // Drive one item and hold it until its transfer. Called at a falling edge,
    // returns at a falling edge. Between bursts, drop valid for a random gap.
    task automatic send_item(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                item_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_valid        = 1'b1;
        cmd               = it.cmd;
        button_index      = it.button_index;
        pin_level         = it.pin_level;
        measured_temp     = it.measured_temp;
        measure_valid     = it.measure_valid;
        schedule_setpoint = it.schedule_setpoint;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
        sent++;
    endtask

    // Unused fields of every item carry random bits.
    task automatic send_tick();
        t_item it;
        it     = t_item'($urandom);
        it.cmd = CMD_TICK;
        send_item(it);
    endtask

    task automatic send_button(input logic [BTN_IDX_W-1:0] btn, input logic level);
        t_item it;
        it              = t_item'($urandom);
        it.cmd          = CMD_EDGE;
        it.button_index = btn;
        it.pin_level    = level;
        send_item(it);
    endtask

    task automatic send_measure(input int temp, input logic ok, input int sched);
        t_item it;
        it                   = t_item'($urandom);
        it.cmd               = CMD_MEAS;
        it.measured_temp     = temp[TEMP_W-1:0];
        it.measure_valid     = ok;
        it.schedule_setpoint = sched[TEMP_W-1:0];
        send_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Write every register, then one index past the list that must be dropped.
    task automatic set_config(input int deb, input int period, input int blink_dur,
                              input int light_dur, input int hyst, input int step,
                              input int init_sp);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_BLINK_PERIOD, period);
        write_reg(CFG_BLINK_DUR, blink_dur);
        write_reg(CFG_BACKLIGHT_DUR, light_dur);
        write_reg(CFG_HYST, hyst);
        write_reg(CFG_STEP, step);
        write_reg(CFG_INIT_SP, init_sp);
        write_reg(CFG_UNUSED, $urandom);
        cur_hyst      = hyst;
        sched_base    = init_sp;
        // longest tick run, sized to reach blink and commit unless capped at 200
        tick_run_max  = (3 * blink_dur + period + 2 > 200) ? 200
                                                           : 3 * blink_dur + period + 2;
        tick_wait_max = (deb + 3 > 40) ? 40 : deb + 3;
    endtask

    // Drop valid, wait until every expected result has arrived, then let the
    // input and result registers settle.
    task automatic settle();
        item_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed traffic: tick runs, press and release pairs spaced
    // around the debounce time, measurements near the setpoint so that the
    // hysteresis band is crossed both ways; a tenth of the episodes is noise.
    task automatic random_phase(input int items);
        int                   stop_at;
        int                   pick;
        int                   spread;
        logic [BTN_IDX_W-1:0] btn;
        t_item                junk;
        stop_at = sent + items;
        while (sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, tick_run_max)) send_tick();
                end
                3, 4, 5: begin
                    pick = $urandom_range(0, 19);
                    btn  = (pick < 9) ? BTN_UP : (pick < 16) ? BTN_DOWN
                         : (pick < 19) ? BTN_MODE : BTN_UNUSED;
                    send_button(btn, 1'b0);
                    repeat ($urandom_range(0, tick_wait_max)) send_tick();
                    send_button(btn, 1'b1);
                    repeat ($urandom_range(0, tick_wait_max)) send_tick();
                end
                6, 7, 8: begin
                    spread = cur_hyst + 4;
                    repeat ($urandom_range(1, 3)) begin
                        send_measure(sched_base + int'($urandom_range(0, 2 * spread)) - spread,
                                     $urandom_range(0, 99) < 85,
                                     ($urandom_range(0, 4) == 0) ? int'($urandom) : sched_base);
                    end
                end
                default: begin
                    junk = t_item'($urandom);
                    send_item(junk);
                end
            endcase
        end
    endtask

    initial begin
        t_item all_ones;
        rst_n             = 1'b0;
        item_valid        = 1'b0;
        cmd               = CMD_TICK;
        button_index      = BTN_UP;
        pin_level         = 1'b1;
        measured_temp     = '0;
        measure_valid     = 1'b0;
        schedule_setpoint = '0;
        cfg_valid         = 1'b0;
        cfg_index         = CFG_DEBOUNCE;
        cfg_data          = '0;
        burst_left        = 0;
        sent              = 0;
        idle_cycles       = 0;
        cur_hyst          = HYST_RST;
        sched_base        = INIT_SP_RST;
        tick_run_max      = 40;
        tick_wait_max     = 33;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset register values.
        send_measure(190, 1'b1, 200);      // below the band: relay on, show setpoint
        send_measure(205, 1'b1, 200);      // above the band: relay off
        send_measure(200, 1'b1, 200);      // equal to setpoint: digits unchanged
        send_measure(2047, 1'b0, -2048);   // invalid: schedule loaded, temp kept
        send_measure(-2048, 1'b1, 2047);   // full-range extremes, unclamped
        send_measure(2047, 1'b1, -2048);
        all_ones     = '1;                  // spare command with every bit set
        all_ones.cmd = CMD_UNDEFINED;
        send_item(all_ones);
        send_tick();
        send_tick();
        send_button(BTN_UP, 1'b0);          // press opens an edit, lights the display
        send_button(BTN_UP, 1'b1);          // release inside the debounce time
        send_button(BTN_DOWN, 1'b0);        // step below range: saturate low
        send_button(BTN_DOWN, 1'b0);        // same level as held: ignored
        send_button(BTN_MODE, 1'b0);        // mode only lights the display
        send_button(BTN_UNUSED, 1'b0);      // index past the bank: ignored
        send_measure(100, 1'b1, 500);       // edit open: schedule not loaded
        send_measure(-1, 1'b0, 0);
        send_tick();

        // Random phases, each on a register setting of its own.
        settle();
        set_config(2, 4, 20, 60, 5, 5, 200);
        random_phase(400);
        settle();
        set_config(0, 0, 1, 1, 0, 1, -400);         // low extremes, zero blink period
        random_phase(300);
        settle();
        set_config(1000, 10000, 60000, 60000, 100, 100, 1250);  // high extremes
        random_phase(150);
        settle();
        set_config(3, 7, 30, 45, 10, 100, 1200);    // big steps into the upper bound
        random_phase(300);
        settle();
        set_config(1, 3, 12, 200, 2, 37, -380);     // steps into the lower bound
        random_phase(300);
        repeat (3) begin
            settle();
            set_config($urandom_range(0, 8), $urandom_range(1, 12), $urandom_range(1, 60),
                       $urandom_range(1, 120), $urandom_range(0, 20), $urandom_range(1, 100),
                       int'($urandom_range(0, 1650)) - 400);
            random_phase(200);
        end
        settle();

        if (mismatches == 0 && pending == 0) begin
            $display("PASS thermostat_setpoint_and_heater_control");
        end else begin
            $display("FAIL thermostat_setpoint_and_heater_control");
        end
        $finish;
    end

endmodule

### thermostat_setpoint_and_heater_control.f
src/thsc_pkg.sv
src/thsc_buttons.sv
src/thsc_ctrl.sv
src/thermostat_setpoint_and_heater_control.sv
tb/thsc_result_checker.sv
tb/thermostat_setpoint_and_heater_control_test.sv
